// ===== rtl/wcst_pkg.sv =====
// ---------------------------------------------------------------------------
// wcst_pkg: shared types and constants of the wave cycle stats tracker
// Request codes, counter numbering, class maps and sequencer states.
// ---------------------------------------------------------------------------
package wcst_pkg;

    localparam int MAX_WAVES_DEF     = 64;
    localparam int COUNTER_WIDTH_DEF = 64;
    localparam int NUM_COUNTERS      = 21;
    localparam int CNT_IDX_W         = 5;

    typedef enum logic [2:0] {
        REQ_LAUNCH   = 3'd0,
        REQ_BEGIN    = 3'd1,
        REQ_WAIT     = 3'd2,
        REQ_RUNNABLE = 3'd3,
        REQ_COMPLETE = 3'd4,
        REQ_TICK     = 3'd5,
        REQ_READ     = 3'd6,
        REQ_NONE     = 3'd7
    } req_t;

    localparam logic [CNT_IDX_W-1:0] CNT_ISSUED = 5'd0;
    localparam logic [CNT_IDX_W-1:0] CNT_INSTS  = 5'd7;
    localparam logic [CNT_IDX_W-1:0] CNT_DONE   = 5'd18;
    localparam logic [CNT_IDX_W-1:0] CNT_LAUNCH = 5'd19;
    localparam logic [CNT_IDX_W-1:0] CNT_CYCLES = 5'd20;
    localparam logic [CNT_IDX_W-1:0] CNT_NONE   = 5'd21;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_BUMP,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // Cycle counter charged for a class, CNT_NONE when the class has none
    function automatic logic [CNT_IDX_W-1:0] cycle_slot_of(input logic [2:0] cls);
        logic [CNT_IDX_W-1:0] r;
        begin
            case (cls)
                3'd0: r = 5'd1;
                3'd1: r = 5'd2;
                3'd2: r = 5'd3;
                3'd3: r = 5'd4;
                3'd5: r = 5'd5;
                3'd6: r = 5'd6;
                default: r = CNT_NONE;
            endcase
            return r;
        end
    endfunction

    function automatic logic [CNT_IDX_W-1:0] inst_slot_of(input logic [2:0] cls);
        logic [CNT_IDX_W-1:0] r;
        begin
            case (cls)
                3'd0: r = 5'd8;
                3'd1: r = 5'd9;
                3'd2: r = 5'd11;
                3'd3: r = 5'd12;
                3'd4: r = 5'd14;
                3'd5: r = 5'd15;
                3'd6: r = 5'd16;
                default: r = 5'd17;
            endcase
            return r;
        end
    endfunction

    function automatic logic [CNT_IDX_W-1:0] extra_slot_of(input logic [2:0] cls);
        logic [CNT_IDX_W-1:0] r;
        begin
            case (cls)
                3'd1: r = 5'd10;
                3'd3: r = 5'd13;
                default: r = CNT_NONE;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/wcst_if.sv =====
// ---------------------------------------------------------------------------
// wcst_req_if / wcst_rsp_if: request and response channels
// Valid/ready handshake carrying the request and response payloads.
// ---------------------------------------------------------------------------
interface wcst_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [5:0]  wave_index;
    logic [2:0]  instr_class;
    logic [15:0] cost;
    logic [11:0] weight;
    logic [4:0]  counter_index;

    modport source (output valid, req_type, wave_index, instr_class, cost, weight,
                    counter_index, input ready);
    modport sink (input valid, req_type, wave_index, instr_class, cost, weight,
                  counter_index, output ready);
endinterface

interface wcst_rsp_if #(parameter int CW = wcst_pkg::COUNTER_WIDTH_DEF);
    logic          valid;
    logic          ready;
    logic [CW-1:0] counter_value;
    logic          all_done;

    modport source (output valid, counter_value, all_done, input ready);
    modport sink (input valid, counter_value, all_done, output ready);
endinterface

// ===== rtl/wave_cycle_stats_tracker_top.sv =====
// ---------------------------------------------------------------------------
// wave_cycle_stats_tracker_top: wave slot table and event counters
// Sequencer around one shared adder that serves every counter update.
// ---------------------------------------------------------------------------
// Usage
//   req: one request per handshake (launch, begin_work, wait, runnable,
//   complete, tick, read_counter). rsp: one response per request carrying
//   counter_value (zero unless a read) and all_done.
//   Slot state sits in a memory with a registered read port; counters sit
//   in a memory too. One adder does every counter read-modify-write.
//   Sequence: a slot request makes one slot access, up to three counter
//   updates (each a read phase, then a write phase), one decision step
//   and the response. A read makes one counter read, none for a counter
//   index above 20. A tick on an empty table goes straight to a decision
//   and the response; else it charges the cycle counter, then per slot a
//   read, a write-back, the counters charged for it and a decision step.
//   One request is in work at a time; req.ready is low until the response
//   has been taken and the sequencer is back in its idle state.
//   A stalled receiver holds the response register and the block with it.
//   Reset: presence and activity bits clear at once; other slot fields
//   are masked while absent, so no clearing pass is needed. Counters are
//   kept in flip-flop valid bits (21 of them) and read as zero until first
//   written.
// ---------------------------------------------------------------------------
module wave_cycle_stats_tracker_top
    import wcst_pkg::*;
#(
    parameter int MAX_WAVES     = wcst_pkg::MAX_WAVES_DEF,
    parameter int COUNTER_WIDTH = wcst_pkg::COUNTER_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    wcst_req_if.sink req,
    wcst_rsp_if.source rsp
);

    localparam int WW = $clog2(MAX_WAVES);
    localparam int CW = COUNTER_WIDTH;
    localparam int SLOT_W = 3 + 16 + 12;

    // Slot storage: control bits in flops, payload in a memory
    logic [MAX_WAVES-1:0] present_reg, present_next;
    logic [MAX_WAVES-1:0] active_reg, active_next;
    logic [SLOT_W-1:0]    slot_mem [MAX_WAVES];
    logic [SLOT_W-1:0]    slot_rd_reg;
    logic                 slot_we;
    logic [WW-1:0]        slot_waddr, slot_raddr;
    logic [SLOT_W-1:0]    slot_wdata;

    // Counter storage
    logic [CW-1:0]           cnt_mem [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] cnt_vld_reg;
    logic [CW-1:0]           cnt_rd_reg;
    logic                    cnt_we;
    logic [CNT_IDX_W-1:0]    cnt_waddr, cnt_raddr;
    logic [CW-1:0]           cnt_wdata;

    state_t               state_reg, state_next;
    req_t                 op_reg, op_next;
    logic [WW-1:0]        wave_reg, wave_next;
    logic [WW:0]          scan_reg, scan_next;
    logic [2:0]           cls_reg, cls_next;
    logic [15:0]          cost_reg, cost_next;
    logic [11:0]          wt_reg, wt_next;
    logic [4:0]           ci_reg, ci_next;
    logic                 slot_ok_reg, slot_ok_next;
    // Pending counter bumps: up to three indexes and an amount
    logic [CNT_IDX_W-1:0] bq_reg [3];
    logic [CNT_IDX_W-1:0] bq_next [3];
    logic [11:0]          amt_reg, amt_next;
    logic                 bphase_reg, bphase_next;
    logic [CW-1:0]        val_reg, val_next;
    logic                 done_reg, done_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[slot_raddr];
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            present_reg   <= '0;
            active_reg    <= '0;
            cnt_vld_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            op_reg        <= REQ_NONE;
            bphase_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
            op_reg        <= op_next;
            bphase_reg    <= bphase_next;
            if (cnt_we && cnt_waddr < CNT_NONE)
            begin
                cnt_vld_reg[cnt_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wave_reg    <= wave_next;
        scan_reg    <= scan_next;
        cls_reg     <= cls_next;
        cost_reg    <= cost_next;
        wt_reg      <= wt_next;
        ci_reg      <= ci_next;
        slot_ok_reg <= slot_ok_next;
        bq_reg      <= bq_next;
        amt_reg     <= amt_next;
        val_reg     <= val_next;
        done_reg    <= done_next;
    end

    // Shared adder: counter read (masked by its valid bit) plus amount
    logic [CW-1:0] cnt_cur;
    logic [CW-1:0] add_sum;
    assign cnt_cur = cnt_vld_reg[cnt_raddr] ? cnt_rd_reg : '0;
    assign add_sum = cnt_cur + CW'(amt_reg);

    // Fields of the slot just read
    logic [2:0]  rd_cls;
    logic [15:0] rd_rem;
    logic [11:0] rd_wt;
    assign {rd_cls, rd_rem, rd_wt} = slot_rd_reg;

    logic [WW-1:0] scan_w;
    assign scan_w = scan_reg[WW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        present_next   = present_reg;
        active_next    = active_reg;
        op_next        = op_reg;
        wave_next      = wave_reg;
        scan_next      = scan_reg;
        cls_next       = cls_reg;
        cost_next      = cost_reg;
        wt_next        = wt_reg;
        ci_next        = ci_reg;
        slot_ok_next   = slot_ok_reg;
        bq_next        = bq_reg;
        amt_next       = amt_reg;
        bphase_next    = bphase_reg;
        val_next       = val_reg;
        done_next      = done_reg;
        rsp_valid_next = rsp_valid_reg;
        slot_we        = 1'b0;
        slot_waddr     = wave_reg;
        slot_raddr     = wave_reg;
        slot_wdata     = '0;
        cnt_we         = 1'b0;
        cnt_waddr      = bq_reg[0];
        cnt_raddr      = bq_reg[0];
        cnt_wdata      = add_sum;
        req.ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next      = req_t'(req.req_type);
                    wave_next    = WW'(req.wave_index);
                    slot_ok_next = 32'(req.wave_index) < MAX_WAVES;
                    cls_next     = req.instr_class;
                    cost_next    = req.cost;
                    wt_next      = req.weight;
                    ci_next      = req.counter_index;
                    val_next     = '0;
                    bq_next[0]   = CNT_NONE;
                    bq_next[1]   = CNT_NONE;
                    bq_next[2]   = CNT_NONE;
                    amt_next     = 12'd1;
                    bphase_next  = 1'b0;
                    scan_next    = '0;
                    state_next   = ST_ACCESS;
                end
            end

            ST_ACCESS:
            begin
                state_next = ST_BUMP;
                case (op_reg)
                    REQ_LAUNCH:
                    begin
                        if (slot_ok_reg)
                        begin
                            if (!present_reg[wave_reg])
                            begin
                                present_next[wave_reg] = 1'b1;
                                active_next[wave_reg]  = 1'b0;
                                slot_we    = 1'b1;
                                slot_wdata = {3'd0, 16'd0, 12'd1};
                            end
                            bq_next[0] = CNT_LAUNCH;
                        end
                    end
                    REQ_BEGIN, REQ_WAIT:
                    begin
                        if (slot_ok_reg)
                        begin
                            if (cost_reg != 16'd0)
                            begin
                                present_next[wave_reg] = 1'b1;
                                active_next[wave_reg]  = 1'b1;
                                slot_we    = 1'b1;
                                slot_wdata = {cls_reg, cost_reg, wt_reg};
                            end
                            else if (present_reg[wave_reg])
                            begin
                                active_next[wave_reg] = 1'b0;
                                slot_we    = 1'b1;
                                slot_wdata = {cls_reg, 16'd0, 12'd1};
                            end
                            if (op_reg == REQ_BEGIN)
                            begin
                                bq_next[0] = CNT_INSTS;
                                bq_next[1] = inst_slot_of(cls_reg);
                                bq_next[2] = extra_slot_of(cls_reg);
                            end
                        end
                    end
                    REQ_RUNNABLE:
                    begin
                        if (slot_ok_reg && present_reg[wave_reg])
                        begin
                            active_next[wave_reg] = 1'b0;
                            slot_we    = 1'b1;
                            slot_wdata = {3'd0, 16'd0, 12'd1};
                        end
                    end
                    REQ_COMPLETE:
                    begin
                        if (slot_ok_reg && present_reg[wave_reg])
                        begin
                            present_next[wave_reg] = 1'b0;
                            active_next[wave_reg]  = 1'b0;
                            bq_next[0] = CNT_DONE;
                        end
                    end
                    REQ_TICK:
                    begin
                        if (present_reg != '0)
                        begin
                            bq_next[0] = CNT_CYCLES;
                        end
                    end
                    REQ_READ:
                    begin
                        bq_next[0] = (ci_reg < CNT_NONE) ? ci_reg : CNT_NONE;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Drain queued counter accesses; bumps go through the shared adder
            ST_BUMP:
            begin
                if (bq_reg[0] == CNT_NONE)
                begin
                    if (op_reg == REQ_TICK && present_reg != '0
                        && scan_reg < (WW+1)'(MAX_WAVES))
                    begin
                        bphase_next = 1'b0;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        done_next      = (present_reg == '0);
                        rsp_valid_next = 1'b1;
                        state_next     = ST_RESULT;
                    end
                end
                else if (!bphase_reg)
                begin
                    bphase_next = 1'b1;
                end
                else
                begin
                    bphase_next = 1'b0;
                    if (op_reg == REQ_READ)
                    begin
                        val_next = cnt_cur;
                    end
                    else
                    begin
                        cnt_we = 1'b1;
                    end
                    bq_next[0] = bq_reg[1];
                    bq_next[1] = bq_reg[2];
                    bq_next[2] = CNT_NONE;
                end
            end

            // Walk one slot: read, then write back and queue its charges
            ST_SCAN:
            begin
                slot_raddr = scan_w;
                if (!bphase_reg)
                begin
                    bphase_next = 1'b1;
                end
                else
                begin
                    bphase_next = 1'b0;
                    scan_next   = scan_reg + 1'b1;
                    state_next  = ST_BUMP;
                    if (present_reg[scan_w] && active_reg[scan_w] && rd_rem != 16'd0)
                    begin
                        slot_we    = 1'b1;
                        slot_waddr = scan_w;
                        if (rd_rem == 16'd1)
                        begin
                            active_next[scan_w] = 1'b0;
                        end
                        slot_wdata = {rd_cls, rd_rem - 16'd1, rd_wt};
                        amt_next   = rd_wt;
                        bq_next[0] = CNT_ISSUED;
                        bq_next[1] = cycle_slot_of(rd_cls);
                    end
                end
            end

            ST_RESULT:
            begin
                if (rsp.ready)
                begin
                    rsp_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.counter_value = val_reg;
    assign rsp.all_done      = done_reg;

    // Response is only offered in its own state
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> state_reg == ST_RESULT)
        else $error("response valid outside result state");

    // No request is taken while a response is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !req.ready)
        else $error("request accepted with response pending");

    // An active slot is always present
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg & ~present_reg) == '0)
        else $error("active slot without presence");

endmodule

// ===== verif/wcst_stats_checker.sv =====
// ---------------------------------------------------------------------------
// wcst_stats_checker: response predictor and comparator
// Watches both channels, keeps its own slot table and counters, predicts the
// response of every accepted request and compares it with the response seen.
// ---------------------------------------------------------------------------
module wcst_stats_checker
    import wcst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wcst_req_if        req,
    wcst_rsp_if        rsp,
    output int         fail_count,
    output int         pending_count
);

    typedef struct packed {
        logic [63:0] counter_value;
        logic        all_done;
    } wcst_rsp_t;

    logic        present   [64];
    logic        active    [64];
    logic [2:0]  cls_tab   [64];
    logic [15:0] remain    [64];
    logic [11:0] wt_tab    [64];
    logic [63:0] stats     [NUM_COUNTERS];
    wcst_rsp_t   rsp_queue [$];

    // Add to one counter; the none index is dropped
    function automatic void charge(logic [CNT_IDX_W-1:0] idx, logic [63:0] amt);
        if (idx < NUM_COUNTERS)
            stats[idx] = stats[idx] + amt;
    endfunction

    function automatic void set_runnable(int w);
        if (present[w])
        begin
            active[w] = 1'b0;
            remain[w] = '0;
            wt_tab[w] = 12'd1;
        end
    endfunction

    function automatic void give_work(int w, logic [2:0] c, logic [15:0] cst,
                                      logic [11:0] wt);
        if (cst == 0)
            set_runnable(w);
        else
        begin
            present[w] = 1'b1;
            active[w]  = 1'b1;
            cls_tab[w] = c;
            remain[w]  = cst;
            wt_tab[w]  = wt;
        end
    endfunction

    function automatic logic table_empty();
        foreach (present[w])
            if (present[w])
                return 1'b0;
        return 1'b1;
    endfunction

    // Apply one request and return the response it causes
    function automatic wcst_rsp_t predict_rsp(logic [2:0] rt, logic [5:0] wi,
            logic [2:0] c, logic [15:0] cst, logic [11:0] wt, logic [4:0] ci);
        wcst_rsp_t r;
        int w;
        r = '0;
        w = int'(wi);
        case (req_t'(rt))
            REQ_LAUNCH:
            begin
                present[w] = 1'b1;
                charge(CNT_LAUNCH, 64'd1);
            end
            REQ_BEGIN:
            begin
                give_work(w, c, cst, wt);
                charge(CNT_INSTS, 64'd1);
                charge(inst_slot_of(c), 64'd1);
                charge(extra_slot_of(c), 64'd1);
            end
            REQ_WAIT:     give_work(w, c, cst, wt);
            REQ_RUNNABLE: set_runnable(w);
            REQ_COMPLETE:
                if (present[w])
                begin
                    charge(CNT_DONE, 64'd1);
                    present[w] = 1'b0;
                    active[w]  = 1'b0;
                    cls_tab[w] = '0;
                    remain[w]  = '0;
                    wt_tab[w]  = 12'd1;
                end
            REQ_TICK:
                if (!table_empty())
                begin
                    charge(CNT_CYCLES, 64'd1);
                    for (int s = 0; s < 64; s++)
                        if (present[s] && active[s] && remain[s] != 0)
                        begin
                            charge(CNT_ISSUED, 64'(wt_tab[s]));
                            charge(cycle_slot_of(cls_tab[s]), 64'(wt_tab[s]));
                            remain[s] = remain[s] - 16'd1;
                            if (remain[s] == 0)
                                active[s] = 1'b0;
                        end
                end
            REQ_READ:
                if (ci < NUM_COUNTERS)
                    r.counter_value = stats[ci];
            default: ;
        endcase
        r.all_done = table_empty();
        return r;
    endfunction

    assign pending_count = rsp_queue.size();

    // Predict on each accepted request, compare on each accepted response
    always @(posedge clk or negedge rst_n)
    begin
        wcst_rsp_t exp_rsp;
        if (!rst_n)
        begin
            for (int w = 0; w < 64; w++)
            begin
                present[w] = 1'b0;
                active[w]  = 1'b0;
                cls_tab[w] = '0;
                remain[w]  = '0;
                wt_tab[w]  = 12'd1;
            end
            foreach (stats[i])
                stats[i] = '0;
            rsp_queue.delete();
            fail_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (rsp_queue.size() == 0)
                begin
                    $error("response with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_rsp = rsp_queue.pop_front();
                    if (rsp.counter_value !== exp_rsp.counter_value)
                    begin
                        $error("counter_value expected %0d actual %0d",
                               exp_rsp.counter_value, rsp.counter_value);
                        fail_count++;
                    end
                    if (rsp.all_done !== exp_rsp.all_done)
                    begin
                        $error("all_done expected %0d actual %0d",
                               exp_rsp.all_done, rsp.all_done);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                rsp_queue.push_back(predict_rsp(req.req_type, req.wave_index,
                    req.instr_class, req.cost, req.weight, req.counter_index));
        end
    end

endmodule

// ===== verif/tb_wave_cycle_stats_tracker_top.sv =====
// ---------------------------------------------------------------------------
// tb_wave_cycle_stats_tracker_top: stimulus and verdict
// Drives directed then random request streams with random gaps and response
// stalls; the checker beside the block predicts and compares every response.
// ---------------------------------------------------------------------------
module tb_wave_cycle_stats_tracker_top;
    import wcst_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   idle_cycles;

    wcst_req_if      req ();
    wcst_rsp_if #(COUNTER_WIDTH_DEF) rsp ();

    wave_cycle_stats_tracker_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    wcst_stats_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles with no handshake; end the run when stuck
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("wave_cycle_stats_tracker_top verification failed");
            $finish;
        end
    end

    // Stall the response side at random
    initial
    begin
        int hold;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(0, 6);
            if (hold != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Send one request, after a random gap
    task automatic send_request(req_t rt, int wi, int c, int cst, int wt, int ci);
        int gap;
        gap = $urandom_range(0, 6);
        @(negedge clk);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.req_type      <= rt;
        req.wave_index    <= 6'(wi);
        req.instr_class   <= 3'(c);
        req.cost          <= 16'(cst);
        req.weight        <= 12'(wt);
        req.counter_index <= 5'(ci);
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Drop valid after the last request
    task automatic end_requests();
        @(negedge clk);
        req.valid <= 1'b0;
    endtask

    task automatic read_all();
        for (int i = 0; i < 24; i++)
            send_request(REQ_READ, $urandom_range(0, 63), 0, 0, 0, i);
    endtask

    initial
    begin
        int pick;
        int wv;
        req.valid = 1'b0;
        req.req_type = REQ_NONE;
        req.wave_index = '0;
        req.instr_class = '0;
        req.cost = '0;
        req.weight = '0;
        req.counter_index = '0;
        idle_cycles = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty tick, absent slot, extremes, every class
        send_request(REQ_TICK, 0, 0, 0, 0, 0);
        send_request(REQ_RUNNABLE, 5, 0, 0, 0, 0);
        send_request(REQ_COMPLETE, 5, 0, 0, 0, 0);
        send_request(REQ_BEGIN, 9, 3, 0, 7, 0);
        send_request(REQ_LAUNCH, 0, 0, 0, 0, 0);
        send_request(REQ_LAUNCH, 0, 0, 0, 0, 0);
        send_request(REQ_LAUNCH, 63, 0, 0, 0, 0);
        for (int c = 0; c < 8; c++)
            send_request(REQ_BEGIN, c + 1, c, 2, 4095 - c, 0);
        send_request(REQ_WAIT, 63, 7, 65535, 0, 0);
        send_request(REQ_WAIT, 20, 1, 1, 4095, 0);
        send_request(REQ_TICK, 0, 0, 0, 0, 0);
        send_request(REQ_TICK, 0, 0, 0, 0, 0);
        send_request(REQ_NONE, 63, 7, 65535, 4095, 31);
        send_request(REQ_READ, 0, 0, 0, 0, 31);
        send_request(REQ_WAIT, 63, 2, 0, 0, 0);
        send_request(REQ_COMPLETE, 63, 0, 0, 0, 0);
        read_all();

        // Random: mostly well-formed wave lifecycles over a few slots
        for (int n = 0; n < 480; n++)
        begin
            pick = $urandom_range(0, 99);
            wv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                             : $urandom_range(0, 7) * 9;
            if (pick < 10)
                send_request(REQ_LAUNCH, wv, 0, 0, 0, 0);
            else if (pick < 35)
                send_request(REQ_BEGIN, wv, $urandom_range(0, 7),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 5),
                    $urandom_range(0, 4095), 0);
            else if (pick < 43)
                send_request(REQ_WAIT, wv, $urandom_range(0, 7),
                    $urandom_range(0, 4), $urandom_range(0, 4095), 0);
            else if (pick < 48)
                send_request(REQ_RUNNABLE, wv, 0, 0, 0, 0);
            else if (pick < 54)
                send_request(REQ_COMPLETE, wv, 0, 0, 0, 0);
            else if (pick < 78)
                send_request(REQ_TICK, wv, 0, 0, 0, 0);
            else if (pick < 97)
                send_request(REQ_READ, wv, 0, 0, 0, $urandom_range(0, 31));
            else
                send_request(REQ_NONE, $urandom_range(0, 63), $urandom_range(0, 7),
                    $urandom_range(0, 65535), $urandom_range(0, 4095),
                    $urandom_range(0, 31));
        end
        read_all();
        end_requests();

        // Drain the outstanding responses, then give the verdict
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("wave_cycle_stats_tracker_top verification clean");
        else
            $display("wave_cycle_stats_tracker_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wcst_pkg.sv
rtl/wcst_if.sv
rtl/wave_cycle_stats_tracker_top.sv
verif/wcst_stats_checker.sv
verif/tb_wave_cycle_stats_tracker_top.sv
